@@ rtl/bta_pkg.sv @@
// Shared types and constants of the binary to ASCII decimal converter.
`timescale 1ns / 1ps

package bta_pkg;

  // Width of the binary value that is converted.
  localparam int VALUE_BITS = 32;
  // Greatest number of characters one value may produce.
  localparam int MAX_DIGITS = 10;
  // BCD digits that hold the largest value of VALUE_BITS bits.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int IDX_W      = $clog2(BCD_DIGITS);
  localparam int DCNT_W     = $clog2(BCD_DIGITS + 1);
  localparam int ITER_W     = $clog2(VALUE_BITS);

  // Front queue between the input port and the converter.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Port field widths.
  localparam int CHAR_W  = 6;
  localparam int LIMIT_W = 6;
  localparam int TDATA_W = 8;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd16;

  // Converter sequencer states.
  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dabble_state_e;

  // Character emitter states.
  typedef enum logic {
    E_IDLE,
    E_SEND
  } emit_state_e;

  // Value leaving the front queue.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
  } queue_out_t;

  // Finished BCD conversion, digit 0 least significant.
  typedef struct packed {
    logic                        valid;
    logic [BCD_DIGITS-1:0][3:0]  digits;
  } conv_out_t;

endpackage

@@ rtl/bta_queue.sv @@
// Front part: accepts input items into a short queue of values.
`timescale 1ns / 1ps

module bta_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [bta_pkg::VALUE_BITS-1:0] value_i,
  output bta_pkg::queue_out_t          q_o,
  input  logic                         pop_i
);

  logic [bta_pkg::VALUE_BITS-1:0] mem_q [bta_pkg::QUEUE_DEPTH];
  logic [bta_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [bta_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           push, pop;

  assign s_tready_o = (cnt_q != bta_pkg::QCNT_W'(bta_pkg::QUEUE_DEPTH));
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = q_o.valid && pop_i;

  assign q_o.valid = (cnt_q != '0);
  assign q_o.value = mem_q[rd_ptr_q];

  // Fill count follows pushes and pops.
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + bta_pkg::QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - bta_pkg::QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + bta_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bta_pkg::QPTR_W'(1);
      end
    end
  end

  // Storage of queued values.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

@@ rtl/bta_dabble.sv @@
// Back part, first stage: iterative shift-add-3 binary to BCD conversion.
`timescale 1ns / 1ps

module bta_dabble (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bta_pkg::queue_out_t q_i,
  output logic                pop_o,
  output bta_pkg::conv_out_t  conv_o,
  input  logic                conv_ready_i
);

  bta_pkg::dabble_state_e state_q, state_d;

  logic [bta_pkg::VALUE_BITS-1:0]      bin_q, bin_d;
  logic [bta_pkg::BCD_DIGITS-1:0][3:0] bcd_q, bcd_d, adj;
  logic [bta_pkg::ITER_W-1:0]          iter_q, iter_d;
  logic                                last_iter;

  assign last_iter = (iter_q == bta_pkg::ITER_W'(bta_pkg::VALUE_BITS - 1));

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < bta_pkg::BCD_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bta_pkg::D_IDLE: if (q_i.valid) state_d = bta_pkg::D_RUN;
      bta_pkg::D_RUN:  if (last_iter) state_d = bta_pkg::D_DONE;
      bta_pkg::D_DONE: if (conv_ready_i) state_d = bta_pkg::D_IDLE;
      default: state_d = bta_pkg::D_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    pop_o        = 1'b0;
    conv_o.valid = 1'b0;
    conv_o.digits = bcd_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    iter_d      = iter_q;
    unique case (state_q)
      bta_pkg::D_IDLE: begin
        pop_o  = 1'b1;
        bin_d  = q_i.value;
        bcd_d  = '0;
        iter_d = '0;
      end
      bta_pkg::D_RUN: begin
        // The top bit shifted out of the highest digit is always zero.
        bcd_d  = bta_pkg::BCD_W'({adj, bin_q[bta_pkg::VALUE_BITS-1]});
        bin_d  = {bin_q[bta_pkg::VALUE_BITS-2:0], 1'b0};
        iter_d = iter_q + bta_pkg::ITER_W'(1);
      end
      bta_pkg::D_DONE: begin
        conv_o.valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::D_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // Conversion registers carry no reset.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

@@ rtl/bta_emit.sv @@
// Back part, second stage: digit count, limit check and character output.
`timescale 1ns / 1ps

module bta_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bta_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  bta_pkg::conv_out_t           conv_i,
  output logic                         conv_ready_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [bta_pkg::CHAR_W-1:0]   char_o,
  output logic                         status_o,
  output logic                         last_o
);

  bta_pkg::emit_state_e state_q, state_d;

  logic [bta_pkg::LIMIT_W-1:0]         limit_q;
  logic [bta_pkg::BCD_DIGITS-1:0][3:0] digits_q;
  logic [bta_pkg::IDX_W-1:0]           idx_q;
  logic                                ovf_q;
  logic [bta_pkg::DCNT_W-1:0]          dcnt;
  logic                                ovf;
  logic                                take, load_out, idx_zero;
  logic                                out_valid_q;
  logic [bta_pkg::CHAR_W-1:0]          out_char_q;
  logic                                out_status_q, out_last_q;

  // Digit count: position of the highest nonzero digit, one for zero.
  always_comb begin
    dcnt = bta_pkg::DCNT_W'(1);
    for (int i = 1; i < bta_pkg::BCD_DIGITS; i++) begin
      if (conv_i.digits[i] != 4'd0) dcnt = bta_pkg::DCNT_W'(i + 1);
    end
  end

  assign ovf = (bta_pkg::LIMIT_W'(dcnt) > limit_q) ||
               (dcnt > bta_pkg::DCNT_W'(bta_pkg::MAX_DIGITS));

  assign idx_zero = (idx_q == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bta_pkg::E_IDLE: if (conv_i.valid) state_d = bta_pkg::E_SEND;
      bta_pkg::E_SEND: if (load_out && (ovf_q || idx_zero)) state_d = bta_pkg::E_IDLE;
      default: state_d = bta_pkg::E_IDLE;
    endcase
  end

  // Handshake outputs of the state machine.
  always_comb begin
    conv_ready_o = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      bta_pkg::E_IDLE:  conv_ready_o = 1'b1;
      bta_pkg::E_SEND:  load_out = !out_valid_q || m_tready_i;
      default: ;
    endcase
  end

  assign take = conv_i.valid && conv_ready_o;

  // Control registers and the column limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bta_pkg::E_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= bta_pkg::LIMIT_RESET;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Digit buffer and output register; digits go out most significant first.
  always_ff @(posedge clk_i) begin
    if (take) begin
      digits_q <= conv_i.digits;
      idx_q    <= bta_pkg::IDX_W'(dcnt - bta_pkg::DCNT_W'(1));
      ovf_q    <= ovf;
    end else if (load_out) begin
      idx_q <= idx_q - bta_pkg::IDX_W'(1);
    end
    if (load_out) begin
      out_char_q   <= ovf_q ? '0 : bta_pkg::ASCII_ZERO + {2'b00, digits_q[idx_q]};
      out_status_q <= ovf_q;
      out_last_q   <= ovf_q || idx_zero;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign char_o     = out_char_q;
  assign status_o   = out_status_q;
  assign last_o     = out_last_q;

endmodule

@@ rtl/binary_to_ascii_decimal_unit.sv @@
// Top level of the binary to ASCII decimal converter.
`timescale 1ns / 1ps

// Converts each unsigned 32-bit input item into its decimal digits as ASCII
// characters, one output item per character, most significant first, with
// tlast on the final character; zero gives the single character '0'. When
// the digit count exceeds the column limit (reset 16, written through
// cfg_we_i/cfg_wdata_i; the user must write it only while idle, as the block
// itself does not enforce this), one item with tuser set, a zero character
// and tlast is given instead. A two-entry input queue feeds a shift-add-3
// converter that works through a load step, 32 shift iterations and a
// hand-off for each value; the emitter sends one character per cycle when
// the output side does not stall, while the converter works on the next
// value.

module binary_to_ascii_decimal_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,  // column_limit
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,    // [31:0] value
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,    // [5:0] ascii_char, [7:6] zero
  output logic        m_tuser_o,    // [0] status
  output logic        m_tlast_o
);

  bta_pkg::queue_out_t             q;
  bta_pkg::conv_out_t              conv;
  logic                            pop;
  logic                            conv_ready;
  logic [bta_pkg::CHAR_W-1:0]      ascii_char;

  bta_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .value_i    (s_tdata_i[bta_pkg::VALUE_BITS-1:0]),
    .q_o        (q),
    .pop_i      (pop)
  );

  bta_dabble u_dabble (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q),
    .pop_o        (pop),
    .conv_o       (conv),
    .conv_ready_i (conv_ready)
  );

  bta_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .conv_i       (conv),
    .conv_ready_o (conv_ready),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .char_o       (ascii_char),
    .status_o     (m_tuser_o),
    .last_o       (m_tlast_o)
  );

  assign m_tdata_o = {{(bta_pkg::TDATA_W - bta_pkg::CHAR_W){1'b0}}, ascii_char};

`ifndef SYNTHESIS
  // An overflow item is a lone, final item with no character.
  a_ovf_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tlast_o && (m_tdata_o == 8'd0)))
    else $error("overflow item not last or carries a character");

  // Every ordinary item carries a decimal digit character.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> ((m_tdata_o >= 8'd48) && (m_tdata_o <= 8'd57)))
    else $error("character outside of the digit range");

  // A finished conversion holds its digits until the emitter takes it.
  a_conv_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conv.valid && !conv_ready) |=> (conv.valid && $stable(conv.digits)))
    else $error("conversion result changed before hand-off");
`endif

endmodule

@@ tb/binary_to_ascii_decimal_unit_test.sv @@
// Self-checking testbench for the binary to ASCII decimal converter.
`timescale 1ns / 1ps

module binary_to_ascii_decimal_unit_test;

  // One expected output item: digit character, status flag and last mark.
  typedef struct packed {
    logic [bta_pkg::CHAR_W-1:0] ch;
    logic                       status;
    logic                       last;
  } char_item_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // Handshake pressure applied during a phase.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Cycles to let pass after the last character.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEMS_PER_PHASE = 15;

  // Column limits for the random phases: extremes, boundaries and out-of-range.
  localparam logic [bta_pkg::LIMIT_W-1:0] PHASE_LIMITS [RANDOM_PHASES] =
    '{6'd1, 6'd40, 6'd0, 6'd63, 6'd5, 6'd10, 6'd9, 6'd3};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bta_pkg::LIMIT_W-1:0]   cfg_wdata_i;
  logic                          s_tvalid_i;
  logic                          s_tready_o;
  logic [31:0]                   s_tdata_i;    // [31:0] value
  logic                          m_tvalid_o;
  logic                          m_tready_i;
  logic [bta_pkg::TDATA_W-1:0]   m_tdata_o;    // [5:0] ascii_char, [7:6] zero
  logic                          m_tuser_o;    // [0] status
  logic                          m_tlast_o;

  logic [bta_pkg::VALUE_BITS-1:0] value_q [$];
  char_item_t                     char_q [$];
  logic [bta_pkg::LIMIT_W-1:0]    column_limit;
  int                             send_idle_pct;
  int                             recv_stall_pct;
  int                             queued_cnt;
  int                             accepted_cnt;
  int                             chars_checked;
  int                             overflow_cnt;
  int                             err_cnt;
  char_item_t                     want_item;

  binary_to_ascii_decimal_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the characters that one value produces under the current limit.
  function automatic void predict_chars(input logic [bta_pkg::VALUE_BITS-1:0] value);
    logic [3:0]                     dig [20];
    logic [bta_pkg::VALUE_BITS-1:0] rest;
    int                             n;
    char_item_t                     item;
    rest = value;
    n = 0;
    do begin
      dig[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    if (n > int'(column_limit) || n > bta_pkg::MAX_DIGITS) begin
      item.ch     = '0;
      item.status = STATUS_OVERFLOW;
      item.last   = 1'b1;
      char_q.push_back(item);
    end else begin
      for (int i = n - 1; i >= 0; i--) begin
        item.ch     = bta_pkg::ASCII_ZERO + bta_pkg::CHAR_W'(dig[i]);
        item.status = STATUS_OK;
        item.last   = (i == 0);
        char_q.push_back(item);
      end
    end
  endfunction

  // Random value: mostly a random digit count, sometimes the full 32-bit range.
  function automatic logic [bta_pkg::VALUE_BITS-1:0] random_value();
    int                             d;
    longint unsigned                p;
    logic [bta_pkg::VALUE_BITS-1:0] lo;
    logic [bta_pkg::VALUE_BITS-1:0] hi;
    if ($urandom_range(4) == 0) return $urandom;
    d = $urandom_range(10, 1);
    p = 1;
    repeat (d - 1) p = p * 10;
    lo = (d == 1) ? '0 : bta_pkg::VALUE_BITS'(p);
    hi = (d == 10) ? '1 : bta_pkg::VALUE_BITS'(p * 10 - 1);
    return $urandom_range(hi, lo);
  endfunction

  task automatic queue_value(input logic [bta_pkg::VALUE_BITS-1:0] value);
    value_q.push_back(value);
    queued_cnt++;
  endtask

  // Waits until every queued value was taken and every character came out.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (accepted_cnt != queued_cnt || char_q.size() != 0);
  endtask

  task automatic write_limit(input logic [bta_pkg::LIMIT_W-1:0] lim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    column_limit = lim;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 86;
      end
      IDLE_RECEIVER: begin
        recv_stall_pct = 86;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 17;
        recv_stall_pct = 17;
      end
      default: ;
    endcase
  endtask

  // Input driver: predicts on acceptance, then offers the next pending value.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        predict_chars(s_tdata_i);
        accepted_cnt++;
      end
      if (!s_tvalid_i || s_tready_o) begin
        if (value_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= value_q.pop_front();
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure and in-order compare of each item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid_o && m_tready_i) begin
        if (char_q.size() == 0) begin
          $display("%0t ns: unexpected item: expected none,", $time);
          $display("  got tdata=%0d tuser=%0b tlast=%0b",
                   m_tdata_o, m_tuser_o, m_tlast_o);
          err_cnt++;
        end else begin
          want_item = char_q.pop_front();
          chars_checked++;
          if (want_item.status == STATUS_OVERFLOW) overflow_cnt++;
          if (m_tdata_o !== bta_pkg::TDATA_W'(want_item.ch) ||
              m_tuser_o !== want_item.status || m_tlast_o !== want_item.last) begin
            $display("%0t ns: mismatch: expected tdata=%0d tuser=%0b tlast=%0b,",
                     $time, bta_pkg::TDATA_W'(want_item.ch), want_item.status,
                     want_item.last);
            $display("  got tdata=%0d tuser=%0b tlast=%0b",
                     m_tdata_o, m_tuser_o, m_tlast_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Stimulus sequence: directed values at the reset limit, then random phases.
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_tvalid_i     = 1'b0;
    s_tdata_i      = '0;
    m_tready_i     = 1'b0;
    column_limit   = bta_pkg::LIMIT_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queued_cnt     = 0;
    accepted_cnt   = 0;
    chars_checked  = 0;
    overflow_cnt   = 0;
    err_cnt        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero, digit-count boundaries, the largest value and bit patterns.
    set_idling(IDLE_NONE);
    queue_value(32'd0);
    queue_value(32'd1);
    queue_value(32'd9);
    queue_value(32'd10);
    queue_value(32'd99);
    queue_value(32'd100);
    queue_value(32'd12345678);
    queue_value(32'd999999999);
    queue_value(32'd1000000000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'hAAAA_AAAA);
    queue_value(32'h5555_5555);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      write_limit(PHASE_LIMITS[ph]);
      set_idling(idle_mode_e'(ph % 4));
      repeat (ITEMS_PER_PHASE) queue_value(random_value());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Converted %0d values into %0d output items, %0d of them overflow reports,",
             accepted_cnt, chars_checked, overflow_cnt);
    $display("over %0d column limits and four handshake pressure modes.", RANDOM_PHASES + 1);
    if (err_cnt == 0) begin
      $display("binary_to_ascii_decimal_unit_test: done, clean");
    end else begin
      $display("binary_to_ascii_decimal_unit_test: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("binary_to_ascii_decimal_unit_test: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bta_pkg.sv
rtl/bta_queue.sv
rtl/bta_dabble.sv
rtl/bta_emit.sv
rtl/binary_to_ascii_decimal_unit.sv
tb/binary_to_ascii_decimal_unit_test.sv
